[src/vgar_pkg.sv]
`timescale 1ns / 1ps
// vgar_pkg: item codes, port offsets and bank address decode for the
// video gate array register block. No dependencies.

package vgar_pkg;

  localparam int EXT_ENTRIES = 32;
  localparam int EXT_IDX_W   = $clog2(EXT_ENTRIES);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [3:0] PORT_MODE   = 4'd8;
  localparam logic [3:0] PORT_COLOR  = 4'd9;
  localparam logic [3:0] PORT_INDEX  = 4'd10;
  localparam logic [3:0] PORT_EXTDAT = 4'd14;
  localparam logic [3:0] PORT_BANK   = 4'd15;

  localparam logic [7:0]  MODE_REDRAW_MASK = 8'h3b;
  localparam logic [7:0]  READ_IDLE        = 8'hff;
  localparam logic [19:0] VIDEO_BASE       = 20'h80000;
  localparam logic [5:0]  BLINK_FRAME      = 6'd63;

  typedef struct packed {
    logic [19:0] disp;
    logic [19:0] acc;
  } bank_bases_t;

  function automatic bank_bases_t bank_decode(input logic [7:0] b);
    bank_bases_t r;
    if (b[7:6] == 2'b11) begin
      r.disp = VIDEO_BASE + {3'b0, b[2:1], 15'b0};
      r.acc  = VIDEO_BASE + {3'b0, b[5:4], 15'b0};
    end else begin
      r.disp = VIDEO_BASE + {3'b0, b[2:0], 14'b0};
      r.acc  = VIDEO_BASE + {3'b0, b[5:3], 14'b0};
    end
    return r;
  endfunction

endpackage

[src/video_gate_array_register_block_top.sv]
`timescale 1ns / 1ps
// Register decode of the video gate array: input register, decode and
// state update, result register. Depends on vgar_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per bus read, bus
//   write or frame tick. Result channel (out_valid/out_ready) returns one
//   beat per input beat, in order: read data, CRTC forward strobe and
//   port select, redraw and palette write pulses, bank base addresses,
//   blink and cursor phases as they stand after the beat is applied.
//   A beat passes through the input register and then the result
//   register; out_valid rises when it moves into the result register.
//   Throughput is one beat per cycle while out_ready is high; the input
//   register and the result register form a two-deep pipeline, so a new
//   beat is taken while a result waits.
//   Registers update when a beat moves from the input register into the
//   result register, so state always follows beat order.
//   When out_ready is low the result holds, the input register fills, and
//   then in_ready drops until the result is taken.
//   Synchronous active-low reset clears valid flags, state registers, the
//   32-entry indexed file and frame counter; no beats are held after reset.

module video_gate_array_register_block_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_port_offset,
  input  logic [7:0]  in_write_value,
  input  logic        in_vertical_retrace,
  input  logic [7:0]  in_crtc_read_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_value,
  output logic        out_crtc_strobe,
  output logic        out_crtc_port_select,
  output logic        out_redraw_all,
  output logic        out_palette_write,
  output logic [3:0]  out_palette_entry,
  output logic [3:0]  out_palette_color,
  output logic [19:0] out_display_base,
  output logic [19:0] out_access_base,
  output logic        out_blink_on,
  output logic        out_cursor_phase
);
  import vgar_pkg::*;

  logic                 s1_valid_r;
  logic [1:0]           s1_kind_r;
  logic [3:0]           s1_port_r;
  logic [7:0]           s1_wv_r;
  logic                 s1_vr_r;
  logic [7:0]           s1_crv_r;

  logic [7:0]           mode_r, mode_nxt;
  logic [7:0]           color_r, color_nxt;
  logic                 toggle_r, toggle_nxt;
  logic [7:0]           index_r, index_nxt;
  logic [7:0]           file_r [EXT_ENTRIES];
  logic [7:0]           bank_r, bank_nxt;
  logic [6:0]           frame_r, frame_nxt;
  logic                 blink_r, blink_nxt;
  logic                 file_we;
  logic [EXT_IDX_W-1:0] slot;

  logic                 out_valid_r;
  logic [7:0]           rd_r, rd_nxt;
  logic                 strobe_r, strobe_nxt;
  logic                 psel_r, psel_nxt;
  logic                 redraw_r, redraw_nxt;
  logic                 pw_r, pw_nxt;
  logic [3:0]           pent_r, pent_nxt;
  logic [3:0]           pcol_r, pcol_nxt;
  logic [19:0]          disp_r, acc_r;
  logic                 blink_out_r, cursor_r;
  bank_bases_t          bases;
  logic                 adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign slot     = index_r[EXT_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind_r <= in_kind;
      s1_port_r <= in_port_offset;
      s1_wv_r   <= in_write_value;
      s1_vr_r   <= in_vertical_retrace;
      s1_crv_r  <= in_crtc_read_value;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    color_nxt  = color_r;
    toggle_nxt = toggle_r;
    index_nxt  = index_r;
    bank_nxt   = bank_r;
    frame_nxt  = frame_r;
    blink_nxt  = blink_r;
    file_we    = 1'b0;
    rd_nxt     = READ_IDLE;
    strobe_nxt = 1'b0;
    psel_nxt   = 1'b0;
    redraw_nxt = 1'b0;
    pw_nxt     = 1'b0;
    pent_nxt   = 4'd0;
    pcol_nxt   = 4'd0;
    case (s1_kind_r)
      KIND_READ: begin
        if (!s1_port_r[3]) begin
          strobe_nxt = 1'b1;
          psel_nxt   = s1_port_r[0];
          rd_nxt     = s1_crv_r;
        end else begin
          case (s1_port_r)
            PORT_MODE:   rd_nxt = mode_r;
            PORT_COLOR:  rd_nxt = color_r;
            PORT_INDEX: begin
              rd_nxt     = {4'b0, s1_vr_r, 2'b0, toggle_r};
              toggle_nxt = !toggle_r;
            end
            PORT_EXTDAT: rd_nxt = file_r[slot];
            PORT_BANK:   rd_nxt = bank_r;
            default:     rd_nxt = READ_IDLE;
          endcase
        end
      end
      KIND_WRITE: begin
        if (!s1_port_r[3]) begin
          strobe_nxt = 1'b1;
          psel_nxt   = s1_port_r[0];
        end else begin
          case (s1_port_r)
            PORT_MODE: begin
              redraw_nxt = |((mode_r ^ s1_wv_r) & MODE_REDRAW_MASK);
              mode_nxt   = s1_wv_r;
            end
            PORT_COLOR: begin
              redraw_nxt = color_r != s1_wv_r;
              color_nxt  = s1_wv_r;
            end
            PORT_INDEX: index_nxt = s1_wv_r;
            PORT_EXTDAT: begin
              file_we  = 1'b1;
              pw_nxt   = slot[EXT_IDX_W-1];
              pent_nxt = slot[EXT_IDX_W-1] ? slot[3:0] : 4'd0;
              pcol_nxt = slot[EXT_IDX_W-1] ? s1_wv_r[3:0] : 4'd0;
            end
            PORT_BANK: begin
              redraw_nxt = bank_r != s1_wv_r;
              bank_nxt   = s1_wv_r;
            end
            default: ;
          endcase
        end
      end
      KIND_TICK: begin
        frame_nxt = frame_r + 7'd1;
        if (frame_nxt[5:0] == BLINK_FRAME) begin
          blink_nxt = frame_nxt[6];
        end
      end
      default: ;
    endcase
    bases = bank_decode(bank_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      color_r  <= '0;
      toggle_r <= 1'b0;
      index_r  <= '0;
      bank_r   <= '0;
      frame_r  <= '0;
      blink_r  <= 1'b0;
      for (int i = 0; i < EXT_ENTRIES; i++) begin
        file_r[i] <= '0;
      end
    end else if (adv) begin
      mode_r   <= mode_nxt;
      color_r  <= color_nxt;
      toggle_r <= toggle_nxt;
      index_r  <= index_nxt;
      bank_r   <= bank_nxt;
      frame_r  <= frame_nxt;
      blink_r  <= blink_nxt;
      if (file_we) begin
        file_r[slot] <= s1_wv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r        <= rd_nxt;
      strobe_r    <= strobe_nxt;
      psel_r      <= psel_nxt;
      redraw_r    <= redraw_nxt;
      pw_r        <= pw_nxt;
      pent_r      <= pent_nxt;
      pcol_r      <= pcol_nxt;
      disp_r      <= bases.disp;
      acc_r       <= bases.acc;
      blink_out_r <= blink_nxt;
      cursor_r    <= frame_nxt[5];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_value       = rd_r;
  assign out_crtc_strobe      = strobe_r;
  assign out_crtc_port_select = psel_r;
  assign out_redraw_all       = redraw_r;
  assign out_palette_write    = pw_r;
  assign out_palette_entry    = pent_r;
  assign out_palette_color    = pcol_r;
  assign out_display_base     = disp_r;
  assign out_access_base      = acc_r;
  assign out_blink_on         = blink_out_r;
  assign out_cursor_phase     = cursor_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  a_frame_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_kind_r == KIND_TICK) |=> (frame_r == $past(frame_r) + 7'd1))
    else $error("frame counter did not advance on tick");

  a_psel_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !strobe_r) |-> !psel_r)
    else $error("CRTC port select without strobe");

  a_palette_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pw_r) |-> (pent_r == 4'd0 && pcol_r == 4'd0))
    else $error("palette fields set without palette write");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && redraw_r) |-> (!strobe_r && !pw_r && rd_r == READ_IDLE))
    else $error("redraw raised alongside another access");

endmodule
